[hdl/lrs_pkg.sv]
// Shared types, codes and helper functions for the logistic-regression SGD engine.
// Depends on nothing; every other file imports this package.
`default_nettype none
package lrs_pkg;

  typedef enum logic [1:0] {
    OP_FEATURE      = 2'd0,
    OP_WRITE_WEIGHT = 2'd1,
    OP_READ_DELTA   = 2'd2,
    OP_READ_SECOND  = 2'd3
  } op_t;

  localparam logic [1:0] CFG_DECAY_RATE    = 2'd0;
  localparam logic [1:0] CFG_APPLY_LOCALLY = 2'd1;
  localparam logic [1:0] CFG_LOCAL_SYNC    = 2'd2;
  localparam logic [1:0] CFG_ACTIVE_DIMS   = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FE_MUL, ST_FE_ACC, ST_RDBACK,
    ST_SIG_IDX, ST_SIG_RD, ST_SIG_P, ST_GAIN, ST_DECAY_Q,
    ST_PASS, ST_G_RD, ST_G_AD, ST_G_WR, ST_D_RD, ST_D_MU, ST_D_WR, ST_EMIT
  } state_t;

  // Update passes, in the order they are applied after a sample.
  typedef enum logic [2:0] {
    PS_GRAD_DELTA, PS_DECAY_DELTA, PS_DECAY_WEIGHT, PS_GRAD_WEIGHT,
    PS_GRAD_SECOND, PS_DECAY_SECOND, PS_DONE
  } pass_t;

  typedef struct packed {
    logic weight;
    logic delta;
    logic second;
  } store_we_t;

  function automatic pass_t next_pass(input pass_t p);
    pass_t r;
    r = PS_DONE;
    unique case (p)
      PS_GRAD_DELTA:   r = PS_DECAY_DELTA;
      PS_DECAY_DELTA:  r = PS_DECAY_WEIGHT;
      PS_DECAY_WEIGHT: r = PS_GRAD_WEIGHT;
      PS_GRAD_WEIGHT:  r = PS_GRAD_SECOND;
      PS_GRAD_SECOND:  r = PS_DECAY_SECOND;
      default:         r = PS_DONE;
    endcase
    return r;
  endfunction

  // Add or subtract a rounded product to a store entry, saturating to 32 bits.
  function automatic logic signed [31:0] sat_acc(input logic signed [31:0] old,
                                                 input logic signed [47:0] inc,
                                                 input logic sub);
    logic signed [49:0] s;
    logic signed [31:0] r;
    s = sub ? (50'(old) - 50'(inc)) : (50'(old) + 50'(inc));
    if (s > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (s < -50'sd2147483648) r = 32'sh80000000;
    else r = s[31:0];
    return r;
  endfunction

  // Shift-subtract division, used only while building the sigmoid table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid of the center of table bucket k, Q0.16.
  function automatic logic [16:0] sig_entry(input int unsigned k, input int unsigned entries);
    logic signed [63:0] x;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] dn;
    logic [63:0] num;
    x = -64'sd524288 + $signed(udiv64(64'(2 * k + 1) * 64'd524288, 64'(entries)));
    t = (x < 0) ? 64'(-x) : 64'(x);
    u = t << 12;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int n = 1; n <= 14; n++) begin
      term = udiv64((term * u) >> 32, 64'(n));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    e = sum;
    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    for (int i = 0; i < 4; i++) e = (e * e) >> 32;
    dn = (64'd1 << 32) + e;
    num = (x >= 0) ? (64'd1 << 48) : (e << 16);
    return 17'(udiv64(num + (dn >> 1), dn));
  endfunction

endpackage
`default_nettype wire

[hdl/lrs_store.sv]
// Weight, delta and second delta stores: three synchronous RAMs sharing addresses.
// Depends on lrs_pkg for the write-enable struct.
`default_nettype none
module lrs_store
  import lrs_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire store_we_t                we,
  input  wire logic signed [31:0]       wdata,
  output logic signed [31:0]            rd_weight,
  output logic signed [31:0]            rd_delta,
  output logic signed [31:0]            rd_second
);

  logic signed [31:0] weight_mem [DEPTH];
  logic signed [31:0] delta_mem  [DEPTH];
  logic signed [31:0] second_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.weight) weight_mem[waddr] <= wdata;
    rd_weight <= weight_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we.delta) delta_mem[waddr] <= wdata;
    rd_delta <= delta_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we.second) second_mem[waddr] <= wdata;
    rd_second <= second_mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/lrs_sig_rom.sv]
// Sigmoid lookup ROM with a registered read port.
// Depends on lrs_pkg for the table-building function.
`default_nettype none
module lrs_sig_rom
  import lrs_pkg::*;
#(
  parameter int ENTRIES = 1024
) (
  input  wire logic                       clk,
  input  wire logic [$clog2(ENTRIES)-1:0] addr,
  output logic [16:0]                     data
);

  logic [16:0] rom [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    localparam logic [16:0] VALUE = sig_entry(k, ENTRIES);
    assign rom[k] = VALUE;
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule
`default_nettype wire

[hdl/logistic_regression_sgd_step_core.sv]
// Top level of the logistic-regression SGD engine: sequencer, sample buffer, datapath.
// Depends on lrs_pkg, lrs_store and lrs_sig_rom.
`default_nettype none
// The engine keeps weights, deltas and second deltas in synchronous RAMs and works on
// one input word at a time. After reset it first runs a clearing pass that zeroes all
// three stores, one entry per cycle, and accepts no word until it is done;
// configuration writes are taken at any time. A weight write goes straight to the
// store. A delta read-back reads the RAM, then, once the output register is free,
// loads the result word and clears the entry. A feature element goes through a
// weight read, a multiply and a 64-bit saturating accumulate. The element marked
// last then starts the update: the sigmoid lookup and the gain and decay factors,
// a pass step to start or skip each pass, then a read-modify-write per buffered
// element for each gradient pass and per active entry for each decay pass, each
// through the single shared 32x32 multiplier, and finally the prediction word is
// delivered.
// Passes run back to back, so a later pass always sees the stores as the earlier ones
// left them. One result word may wait in the output register while the next input
// word is accepted.
module logistic_regression_sgd_step_core
  import lrs_pkg::*;
#(
  parameter int MAX_DIMS        = 4096,
  parameter int MAX_NONZEROS    = 256,
  parameter int SIGMOID_ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // elem_index [11:0], elem_value [43:12], class_label [44], step_size [61:45]
  input  wire logic [63:0] s_tdata,
  // opcode [1:0]
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // probability [16:0], delta_data [48:17], echo_index [60:49]
  output logic [63:0]      m_tdata,
  // result_kind [0]
  output logic             m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Entries above 4095 are never addressed, so the stores stop there.
  localparam int DEPTH = (MAX_DIMS < 4096) ? MAX_DIMS : 4096;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(DEPTH + 1);
  localparam int CNTW  = $clog2(MAX_NONZEROS + 1);
  localparam int BAW   = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int IW    = $clog2(SIGMOID_ENTRIES);

  // Configuration registers.
  logic [15:0] decay_rate;
  logic        apply_locally;
  logic        local_sync;
  logic [12:0] active_dims;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate    <= '0;
      apply_locally <= 1'b1;
      local_sync    <= 1'b0;
      active_dims   <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECAY_RATE:    decay_rate    <= cfg_data;
        CFG_APPLY_LOCALLY: apply_locally <= cfg_data[0];
        CFG_LOCAL_SYNC:    local_sync    <= cfg_data[0];
        CFG_ACTIVE_DIMS:   active_dims   <= cfg_data[12:0];
        default:           ;
      endcase
    end
  end

  // Effective dimension count and the length of a decay walk.
  logic [12:0]   n_eff;
  logic [WW-1:0] walk_len;
  assign n_eff    = (32'(active_dims) < 32'(MAX_DIMS)) ? active_dims : 13'(MAX_DIMS);
  assign walk_len = (32'(n_eff) < 32'(DEPTH)) ? WW'(n_eff) : WW'(DEPTH);

  // Input word fields.
  op_t                in_op;
  logic [11:0]        in_idx;
  logic signed [31:0] in_val;
  logic               in_range;
  logic               in_take;
  assign in_op    = op_t'(s_tuser);
  assign in_idx   = s_tdata[11:0];
  assign in_val   = s_tdata[43:12];
  assign in_range = ({1'b0, in_idx} < n_eff);

  state_t state, state_next;
  pass_t  pass;

  logic [11:0]        cap_idx;
  logic signed [31:0] cap_val;
  logic               cap_label;
  logic [16:0]        cap_lr;
  logic               cap_last;
  logic               cap_range;
  logic               cap_second;

  logic signed [63:0] dot;
  logic [CNTW-1:0]    buf_cnt;
  logic [CNTW-1:0]    gi;
  logic [WW-1:0]      wj;
  logic signed [63:0] prod;
  logic signed [31:0] gain;
  logic signed [31:0] dq;
  logic [16:0]        prob;
  logic [IW-1:0]      sig_idx;
  logic [16:0]        sig_data;

  assign in_take = in_range && (buf_cnt < CNTW'(MAX_NONZEROS));

  // Sample buffer: {index, value} of each accepted element.
  logic [43:0]    sbuf [MAX_NONZEROS];
  logic [43:0]    buf_rd;
  logic           buf_we;
  logic [BAW-1:0] buf_raddr;
  logic [11:0]    buf_ix;
  logic signed [31:0] buf_val;
  assign buf_ix  = buf_rd[43:32];
  assign buf_val = buf_rd[31:0];

  always_ff @(posedge clk) begin
    if (buf_we) sbuf[buf_cnt[BAW-1:0]] <= {in_idx, in_val};
    buf_rd <= sbuf[buf_raddr];
  end

  // Stores.
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  store_we_t          we;
  logic signed [31:0] wdata;
  logic signed [31:0] rd_weight;
  logic signed [31:0] rd_delta;
  logic signed [31:0] rd_second;

  lrs_store #(.DEPTH(DEPTH)) u_store (
    .clk       (clk),
    .raddr     (raddr),
    .waddr     (waddr),
    .we        (we),
    .wdata     (wdata),
    .rd_weight (rd_weight),
    .rd_delta  (rd_delta),
    .rd_second (rd_second)
  );

  lrs_sig_rom #(.ENTRIES(SIGMOID_ENTRIES)) u_sig_rom (
    .clk  (clk),
    .addr (sig_idx),
    .data (sig_data)
  );

  // Which store the current pass updates, and its read data.
  store_we_t          tgt_we;
  logic signed [31:0] tgt_rd;
  logic               pass_on;
  logic               pass_grad;

  always_comb begin
    tgt_we    = '{weight: 1'b0, delta: 1'b1, second: 1'b0};
    tgt_rd    = rd_delta;
    pass_on   = 1'b1;
    pass_grad = 1'b1;
    case (pass)
      PS_GRAD_DELTA: ;
      PS_DECAY_DELTA: begin
        pass_on   = (decay_rate != '0);
        pass_grad = 1'b0;
      end
      PS_DECAY_WEIGHT: begin
        tgt_we    = '{weight: 1'b1, delta: 1'b0, second: 1'b0};
        tgt_rd    = rd_weight;
        pass_on   = apply_locally && (decay_rate != '0);
        pass_grad = 1'b0;
      end
      PS_GRAD_WEIGHT: begin
        tgt_we  = '{weight: 1'b1, delta: 1'b0, second: 1'b0};
        tgt_rd  = rd_weight;
        pass_on = apply_locally;
      end
      PS_GRAD_SECOND: begin
        tgt_we  = '{weight: 1'b0, delta: 1'b0, second: 1'b1};
        tgt_rd  = rd_second;
        pass_on = local_sync;
      end
      PS_DECAY_SECOND: begin
        tgt_we    = '{weight: 1'b0, delta: 1'b0, second: 1'b1};
        tgt_rd    = rd_second;
        pass_on   = local_sync && (decay_rate != '0);
        pass_grad = 1'b0;
      end
      default: pass_on = 1'b0;
    endcase
  end

  logic pass_go;
  assign pass_go = pass_on && (pass_grad ? (buf_cnt != '0) : (walk_len != '0));

  // Round-half-up of the registered product, and the two store updates.
  logic signed [63:0] prod_rnd;
  logic signed [47:0] rnd48;
  logic signed [31:0] sat_up;
  logic signed [31:0] sat_dn;
  assign prod_rnd = prod + 64'sd32768;
  assign rnd48    = prod_rnd[63:16];
  assign sat_up   = sat_acc(tgt_rd, rnd48, 1'b0);
  assign sat_dn   = sat_acc(tgt_rd, rnd48, 1'b1);

  // Saturating dot-product accumulate.
  logic signed [64:0] dot_sum;
  logic signed [63:0] dot_sat;
  assign dot_sum = {dot[63], dot} + {prod[63], prod};
  always_comb begin
    if (dot_sum[64] != dot_sum[63])
      dot_sat = dot_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      dot_sat = dot_sum[63:0];
  end

  // Sigmoid bucket: the range [-8, 8) in Q32.32 is split into SIGMOID_ENTRIES buckets.
  logic signed [63:0] sig_off;
  logic [50:0]        sig_mul;
  logic [14:0]        sig_raw;
  logic [IW-1:0]      sig_calc;
  assign sig_off = dot + 64'sd34359738368;
  assign sig_mul = 51'(sig_off[35:0]) * 51'(SIGMOID_ENTRIES);
  assign sig_raw = sig_mul[50:36];
  always_comb begin
    if (dot < -64'sd34359738368)
      sig_calc = '0;
    else if (dot >= 64'sd34359738368 || sig_raw >= 15'(SIGMOID_ENTRIES))
      sig_calc = IW'(SIGMOID_ENTRIES - 1);
    else
      sig_calc = sig_raw[IW-1:0];
  end

  logic slot_free;
  logic out_load;
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic [WW-1:0]      wj_inc;
  logic [CNTW-1:0]    gi_inc;
  assign wj_inc = wj + WW'(1);
  assign gi_inc = gi + CNTW'(1);

  // Next state and control.
  always_comb begin
    state_next = state;
    we         = '0;
    raddr      = cap_idx[AW-1:0];
    waddr      = cap_idx[AW-1:0];
    wdata      = '0;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    buf_we     = 1'b0;
    buf_raddr  = gi[BAW-1:0];
    unique case (state)
      ST_CLEAR: begin
        we    = '{weight: 1'b1, delta: 1'b1, second: 1'b1};
        waddr = wj[AW-1:0];
        if (wj == WW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        raddr = in_idx[AW-1:0];
        waddr = in_idx[AW-1:0];
        wdata = in_val;
        if (s_tvalid) begin
          unique case (in_op)
            OP_FEATURE: begin
              if (in_take) begin
                buf_we     = 1'b1;
                state_next = ST_FE_MUL;
              end else if (s_tlast) begin
                state_next = ST_SIG_IDX;
              end
            end
            OP_WRITE_WEIGHT: we.weight = in_range;
            OP_READ_DELTA, OP_READ_SECOND: state_next = ST_RDBACK;
            default: ;
          endcase
        end
      end
      ST_FE_MUL: begin
        mul_a      = rd_weight;
        mul_b      = cap_val;
        state_next = ST_FE_ACC;
      end
      ST_FE_ACC: state_next = cap_last ? ST_SIG_IDX : ST_IDLE;
      ST_RDBACK: begin
        if (slot_free) begin
          out_load   = 1'b1;
          we.delta   = cap_range && !cap_second;
          we.second  = cap_range && cap_second;
          state_next = ST_IDLE;
        end
      end
      ST_SIG_IDX: state_next = ST_SIG_RD;
      ST_SIG_RD:  state_next = ST_SIG_P;
      ST_SIG_P: begin
        // Negated error: label - p, so the gain needs no separate negation.
        mul_a      = $signed({15'd0, cap_lr});
        mul_b      = (cap_label ? 32'sd65536 : 32'sd0) - $signed({15'd0, sig_data});
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        mul_a      = $signed({15'd0, cap_lr});
        mul_b      = $signed({16'd0, decay_rate});
        state_next = ST_DECAY_Q;
      end
      ST_DECAY_Q: state_next = ST_PASS;
      ST_PASS: begin
        if (pass == PS_DONE) state_next = ST_EMIT;
        else if (pass_go) state_next = pass_grad ? ST_G_RD : ST_D_RD;
      end
      ST_G_RD: state_next = ST_G_AD;
      ST_G_AD: begin
        raddr      = buf_ix[AW-1:0];
        mul_a      = gain;
        mul_b      = buf_val;
        state_next = ST_G_WR;
      end
      ST_G_WR: begin
        raddr     = buf_ix[AW-1:0];
        waddr     = buf_ix[AW-1:0];
        wdata     = sat_up;
        we        = tgt_we;
        buf_raddr = gi_inc[BAW-1:0];
        state_next = (gi_inc < buf_cnt) ? ST_G_AD : ST_PASS;
      end
      ST_D_RD: begin
        raddr      = wj[AW-1:0];
        state_next = ST_D_MU;
      end
      ST_D_MU: begin
        raddr      = wj[AW-1:0];
        mul_a      = dq;
        mul_b      = rd_weight;
        state_next = ST_D_WR;
      end
      ST_D_WR: begin
        // The next entry is read while this one is written back.
        raddr      = wj_inc[AW-1:0];
        waddr      = wj[AW-1:0];
        wdata      = sat_dn;
        we         = tgt_we;
        state_next = (wj_inc < walk_len) ? ST_D_MU : ST_PASS;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Counters and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wj      <= '0;
      gi      <= '0;
      buf_cnt <= '0;
      dot     <= '0;
      pass    <= PS_DONE;
    end else begin
      case (state)
        ST_CLEAR: wj <= (wj == WW'(DEPTH - 1)) ? '0 : wj_inc;
        ST_IDLE: begin
          if (s_tvalid && in_op == OP_FEATURE && in_take) buf_cnt <= buf_cnt + CNTW'(1);
        end
        ST_FE_ACC: dot <= dot_sat;
        ST_DECAY_Q: pass <= PS_GRAD_DELTA;
        ST_PASS: begin
          gi <= '0;
          wj <= '0;
          if (pass != PS_DONE && !pass_go) pass <= next_pass(pass);
        end
        ST_G_WR: begin
          gi <= gi_inc;
          if (!(gi_inc < buf_cnt)) pass <= next_pass(pass);
        end
        ST_D_WR: begin
          wj <= wj_inc;
          if (!(wj_inc < walk_len)) pass <= next_pass(pass);
        end
        ST_EMIT: begin
          if (slot_free) begin
            dot     <= '0;
            buf_cnt <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      cap_idx    <= in_idx;
      cap_val    <= in_val;
      cap_label  <= s_tdata[44];
      cap_lr     <= s_tdata[61:45];
      cap_last   <= s_tlast;
      cap_range  <= in_range;
      cap_second <= (in_op == OP_READ_SECOND);
    end
    if (state == ST_SIG_IDX) sig_idx <= sig_calc;
    if (state == ST_SIG_P) prob <= sig_data;
    if (state == ST_GAIN) gain <= rnd48[31:0];
    if (state == ST_DECAY_Q) dq <= rnd48[31:0];
  end

  // Output register.
  logic               out_kind;
  logic [16:0]        out_prob;
  logic signed [31:0] out_delta;
  logic [11:0]        out_echo;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_RDBACK) begin
        out_kind  <= 1'b1;
        out_prob  <= '0;
        out_delta <= cap_range ? (cap_second ? rd_second : rd_delta) : 32'sd0;
        out_echo  <= cap_idx;
      end else begin
        out_kind  <= 1'b0;
        out_prob  <= prob;
        out_delta <= '0;
        out_echo  <= '0;
      end
    end
  end

  assign m_tdata = {3'd0, out_echo, out_delta, out_prob};
  assign m_tuser = out_kind;

endmodule
`default_nettype wire
